>>> rtl/pl0sm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PL/0 stack machine package
// Shared types, opcodes, operator codes, fault codes and decode helpers.
// ----------------------------------------------------------------------------
package pl0sm_pkg;

    localparam int CMD_W  = 3;
    localparam int LEV_W  = 2;
    localparam int ADR_W  = 11;
    localparam int PC_W   = 11;
    localparam int TOP_W  = 13;
    localparam int FB_W   = 12;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 34;
    localparam int FLT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LIT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STO = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CAL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_JMP = 3'd6;
    localparam logic [CMD_W-1:0] CMD_JPC = 3'd7;

    localparam logic [ADR_W-1:0] OPR_RET = 11'd0;
    localparam logic [ADR_W-1:0] OPR_NEG = 11'd1;
    localparam logic [ADR_W-1:0] OPR_ADD = 11'd2;
    localparam logic [ADR_W-1:0] OPR_SUB = 11'd3;
    localparam logic [ADR_W-1:0] OPR_MUL = 11'd4;
    localparam logic [ADR_W-1:0] OPR_DIV = 11'd5;
    localparam logic [ADR_W-1:0] OPR_ODD = 11'd6;
    localparam logic [ADR_W-1:0] OPR_EQ  = 11'd8;
    localparam logic [ADR_W-1:0] OPR_NE  = 11'd9;
    localparam logic [ADR_W-1:0] OPR_LT  = 11'd10;
    localparam logic [ADR_W-1:0] OPR_GE  = 11'd11;
    localparam logic [ADR_W-1:0] OPR_GT  = 11'd12;
    localparam logic [ADR_W-1:0] OPR_LE  = 11'd13;

    localparam logic [FLT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FLT_W-1:0] FAULT_DIV   = 2'd1;
    localparam logic [FLT_W-1:0] FAULT_STACK = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_WALK_W,
        S_RDA,
        S_RDA_W,
        S_RDB,
        S_RDB_W,
        S_DIV_SET,
        S_DIV,
        S_EXEC,
        S_WR2,
        S_WR3,
        S_TOP,
        S_TOP_W,
        S_OUT
    } t_state;

    function automatic logic f_is_binop(input logic [ADR_W-1:0] adr);
        logic r;
        r = ((adr >= OPR_ADD) && (adr <= OPR_DIV)) || ((adr >= OPR_EQ) && (adr <= OPR_LE));
        return r;
    endfunction

    function automatic logic f_needs_walk(input logic [CMD_W-1:0] cmd);
        logic r;
        r = (cmd == CMD_LOD) || (cmd == CMD_STO) || (cmd == CMD_CAL);
        return r;
    endfunction

    function automatic logic f_needs_a(input logic [CMD_W-1:0] cmd,
                                       input logic [ADR_W-1:0] adr);
        logic r;
        r = (cmd == CMD_LOD) || (cmd == CMD_STO) || (cmd == CMD_JPC) ||
            ((cmd == CMD_OPR) && ((adr == OPR_RET) || (adr == OPR_NEG) ||
                                  (adr == OPR_ODD) || f_is_binop(adr)));
        return r;
    endfunction

    function automatic logic f_needs_b(input logic [CMD_W-1:0] cmd,
                                       input logic [ADR_W-1:0] adr);
        logic r;
        r = (cmd == CMD_OPR) && ((adr == OPR_RET) || f_is_binop(adr));
        return r;
    endfunction

endpackage

>>> rtl/pl0_pcode_stack_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine
// Executes one p-code instruction per request against a data stack in RAM.
// ----------------------------------------------------------------------------
// The input channel takes one instruction (command, level, address) per
// request; o_stall is high whenever the machine is busy. The output channel
// returns one result per instruction: next program counter, top pointer, top
// value, halted flag and fault code. The result is held on the ports with
// o_valid high until i_stall is low, and the next request is taken after that.
// All stack traffic goes through one RAM, one access per cycle with a
// registered read. An instruction may walk the static links level by
// level, read up to two stack words, execute, make the extra frame writes
// of a call, then read the top value and present the result. A divide runs
// through a radix-2 divider, which is skipped when the divisor is zero.
// After reset the top pointer is -1 and the frame base and program counter
// are 0. The machine first clears the stack RAM, one word per cycle, while
// o_stall stays high.
// ----------------------------------------------------------------------------
module pl0_pcode_stack_machine #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_LEVEL   = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic [1:0]         i_level,
    input  logic [10:0]        i_address,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [10:0]        o_next_pc,
    output logic signed [12:0] o_top_index,
    output logic signed [31:0] o_top_value,
    output logic               o_halted,
    output logic [1:0]         o_fault
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = pl0sm_pkg::IDX_W;
    localparam int DW = pl0sm_pkg::DATA_W;

    pl0sm_pkg::t_state r_state, n_state;

    logic [pl0sm_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic [pl0sm_pkg::LEV_W-1:0]        r_cnt, n_cnt;
    logic [pl0sm_pkg::ADR_W-1:0]        r_adr, n_adr;
    logic signed [pl0sm_pkg::TOP_W-1:0] r_top, n_top;
    logic [pl0sm_pkg::FB_W-1:0]         r_fb, n_fb;
    logic [pl0sm_pkg::PC_W-1:0]         r_pc, n_pc;
    logic signed [IW-1:0]               r_t, n_t;
    logic [pl0sm_pkg::PC_W-1:0]         r_p, n_p;
    logic signed [IW-1:0]               r_base, n_base;
    logic [DW-1:0]                      r_lhs, n_lhs;
    logic [DW-1:0]                      r_rhs, n_rhs;
    logic [pl0sm_pkg::FLT_W-1:0]        r_fault, n_fault;
    logic                               r_oob, n_oob;
    logic [AW-1:0]                      r_clr, n_clr;
    logic [4:0]                         r_dcnt, n_dcnt;
    logic [DW-1:0]                      r_rem, n_rem;
    logic [DW-1:0]                      r_quo, n_quo;
    logic [DW-1:0]                      r_dvs, n_dvs;
    logic                               r_neg, n_neg;
    logic [pl0sm_pkg::PC_W-1:0]         r_out_pc, n_out_pc;
    logic signed [pl0sm_pkg::TOP_W-1:0] r_out_top, n_out_top;
    logic [DW-1:0]                      r_out_val, n_out_val;
    logic                               r_out_halt, n_out_halt;
    logic [pl0sm_pkg::FLT_W-1:0]        r_out_fault, n_out_fault;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [DW-1:0]        ram_q;
    logic [DW-1:0]        rdata;
    logic signed [IW-1:0] rd_idx;
    logic                 rd_go;
    logic signed [IW-1:0] wr_idx;
    logic [DW-1:0]        wr_data;
    logic                 wr_go;
    logic signed [IW-1:0] adr_s;
    logic signed [IW-1:0] fb_s;
    logic signed [IW-1:0] top_s;
    logic [DW-1:0]        alu;
    logic [DW:0]          trial;
    logic [DW:0]          dvs_x;
    logic [3:0]           lev_eff;

    function automatic logic f_in_range(input logic signed [IW-1:0] idx);
        logic r;
        r = (idx >= $signed(34'd0)) && (idx < $signed(IW'(STACK_DEPTH)));
        return r;
    endfunction

    pl0sm_ram #(
        .WIDTH(DW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    assign rdata   = r_oob ? '0 : ram_q;
    assign adr_s   = $signed({{(IW-pl0sm_pkg::ADR_W){1'b0}}, r_adr});
    assign fb_s    = $signed({{(IW-pl0sm_pkg::FB_W){1'b0}}, r_fb});
    assign top_s   = {{(IW-pl0sm_pkg::TOP_W){r_t[pl0sm_pkg::TOP_W-1]}},
                      r_t[pl0sm_pkg::TOP_W-1:0]};
    assign lev_eff = ({2'b00, i_level} > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : {2'b00, i_level};
    assign dvs_x   = {1'b0, r_dvs};
    assign trial   = {r_rem, r_quo[DW-1]};

    always_comb begin
        alu = '0;
        case (r_adr)
            pl0sm_pkg::OPR_ADD: alu = r_lhs + r_rhs;
            pl0sm_pkg::OPR_SUB: alu = r_lhs - r_rhs;
            pl0sm_pkg::OPR_MUL: alu = r_lhs * r_rhs;
            pl0sm_pkg::OPR_DIV: alu = (r_rhs == '0) ? '0 : (r_neg ? (32'd0 - r_quo) : r_quo);
            pl0sm_pkg::OPR_EQ:  alu = {31'd0, r_lhs == r_rhs};
            pl0sm_pkg::OPR_NE:  alu = {31'd0, r_lhs != r_rhs};
            pl0sm_pkg::OPR_LT:  alu = {31'd0, $signed(r_lhs) <  $signed(r_rhs)};
            pl0sm_pkg::OPR_GE:  alu = {31'd0, $signed(r_lhs) >= $signed(r_rhs)};
            pl0sm_pkg::OPR_GT:  alu = {31'd0, $signed(r_lhs) >  $signed(r_rhs)};
            pl0sm_pkg::OPR_LE:  alu = {31'd0, $signed(r_lhs) <= $signed(r_rhs)};
            default:            alu = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_adr       = r_adr;
        n_top       = r_top;
        n_fb        = r_fb;
        n_pc        = r_pc;
        n_t         = r_t;
        n_p         = r_p;
        n_base      = r_base;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_fault     = r_fault;
        n_oob       = r_oob;
        n_clr       = r_clr;
        n_dcnt      = r_dcnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_out_pc    = r_out_pc;
        n_out_top   = r_out_top;
        n_out_val   = r_out_val;
        n_out_halt  = r_out_halt;
        n_out_fault = r_out_fault;
        rd_idx      = '0;
        rd_go       = 1'b0;
        wr_idx      = '0;
        wr_data     = '0;
        wr_go       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;

        unique case (r_state)
            pl0sm_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(STACK_DEPTH - 1)) begin
                    n_state = pl0sm_pkg::S_IDLE;
                end
            end
            pl0sm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_adr   = i_address;
                    n_cnt   = lev_eff[1:0];
                    n_t     = {{(IW-pl0sm_pkg::TOP_W){r_top[pl0sm_pkg::TOP_W-1]}}, r_top};
                    n_p     = r_pc + 11'd1;
                    n_base  = fb_s;
                    n_fault = pl0sm_pkg::FAULT_NONE;
                    if (pl0sm_pkg::f_needs_walk(i_command) && (lev_eff != 4'd0)) begin
                        n_state = pl0sm_pkg::S_WALK;
                    end else if (pl0sm_pkg::f_needs_a(i_command, i_address)) begin
                        n_state = pl0sm_pkg::S_RDA;
                    end else begin
                        n_state = pl0sm_pkg::S_EXEC;
                    end
                end
            end
            pl0sm_pkg::S_WALK: begin
                rd_idx  = r_base;
                rd_go   = 1'b1;
                n_state = pl0sm_pkg::S_WALK_W;
            end
            pl0sm_pkg::S_WALK_W: begin
                n_base = {{(IW-DW){rdata[DW-1]}}, rdata};
                n_cnt  = r_cnt - 2'd1;
                if (r_cnt != 2'd1) begin
                    n_state = pl0sm_pkg::S_WALK;
                end else if (pl0sm_pkg::f_needs_a(r_cmd, r_adr)) begin
                    n_state = pl0sm_pkg::S_RDA;
                end else begin
                    n_state = pl0sm_pkg::S_EXEC;
                end
            end
            pl0sm_pkg::S_RDA: begin
                rd_go = 1'b1;
                if (r_cmd == pl0sm_pkg::CMD_LOD) begin
                    rd_idx = r_base + adr_s;
                end else if ((r_cmd == pl0sm_pkg::CMD_OPR) && (r_adr == pl0sm_pkg::OPR_RET)) begin
                    rd_idx = fb_s + 34'sd2;
                end else begin
                    rd_idx = r_t;
                end
                n_state = pl0sm_pkg::S_RDA_W;
            end
            pl0sm_pkg::S_RDA_W: begin
                n_rhs = rdata;
                if (pl0sm_pkg::f_needs_b(r_cmd, r_adr)) begin
                    n_state = pl0sm_pkg::S_RDB;
                end else begin
                    n_state = pl0sm_pkg::S_EXEC;
                end
            end
            pl0sm_pkg::S_RDB: begin
                rd_go = 1'b1;
                if (r_adr == pl0sm_pkg::OPR_RET) begin
                    rd_idx = fb_s + 34'sd1;
                end else begin
                    rd_idx = r_t - 34'sd1;
                end
                n_state = pl0sm_pkg::S_RDB_W;
            end
            pl0sm_pkg::S_RDB_W: begin
                n_lhs = rdata;
                if (r_adr == pl0sm_pkg::OPR_DIV) begin
                    n_state = pl0sm_pkg::S_DIV_SET;
                end else begin
                    n_state = pl0sm_pkg::S_EXEC;
                end
            end
            pl0sm_pkg::S_DIV_SET: begin
                n_rem  = '0;
                n_quo  = r_lhs[DW-1] ? (32'd0 - r_lhs) : r_lhs;
                n_dvs  = r_rhs[DW-1] ? (32'd0 - r_rhs) : r_rhs;
                n_neg  = r_lhs[DW-1] ^ r_rhs[DW-1];
                n_dcnt = 5'd31;
                if (r_rhs == '0) begin
                    n_state = pl0sm_pkg::S_EXEC;
                end else begin
                    n_state = pl0sm_pkg::S_DIV;
                end
            end
            pl0sm_pkg::S_DIV: begin
                if (trial >= dvs_x) begin
                    n_rem = DW'(trial - dvs_x);
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = trial[DW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - 5'd1;
                if (r_dcnt == 5'd0) begin
                    n_state = pl0sm_pkg::S_EXEC;
                end
            end
            pl0sm_pkg::S_EXEC: begin
                n_state = pl0sm_pkg::S_TOP;
                unique case (r_cmd)
                    pl0sm_pkg::CMD_LIT: begin
                        n_t     = r_t + 34'sd1;
                        wr_idx  = r_t + 34'sd1;
                        wr_data = {21'd0, r_adr};
                        wr_go   = 1'b1;
                    end
                    pl0sm_pkg::CMD_OPR: begin
                        if (r_adr == pl0sm_pkg::OPR_RET) begin
                            n_t  = fb_s - 34'sd1;
                            n_p  = r_rhs[pl0sm_pkg::PC_W-1:0];
                            n_fb = r_lhs[pl0sm_pkg::FB_W-1:0];
                        end else if (r_adr == pl0sm_pkg::OPR_NEG) begin
                            wr_idx  = r_t;
                            wr_data = 32'd0 - r_rhs;
                            wr_go   = 1'b1;
                        end else if (r_adr == pl0sm_pkg::OPR_ODD) begin
                            wr_idx  = r_t;
                            wr_data = {31'd0, r_rhs[0]};
                            wr_go   = 1'b1;
                        end else if (pl0sm_pkg::f_is_binop(r_adr)) begin
                            if ((r_adr == pl0sm_pkg::OPR_DIV) && (r_rhs == '0) &&
                                (r_fault == pl0sm_pkg::FAULT_NONE)) begin
                                n_fault = pl0sm_pkg::FAULT_DIV;
                            end
                            n_t     = r_t - 34'sd1;
                            wr_idx  = r_t - 34'sd1;
                            wr_data = alu;
                            wr_go   = 1'b1;
                        end
                    end
                    pl0sm_pkg::CMD_LOD: begin
                        n_t     = r_t + 34'sd1;
                        wr_idx  = r_t + 34'sd1;
                        wr_data = r_rhs;
                        wr_go   = 1'b1;
                    end
                    pl0sm_pkg::CMD_STO: begin
                        n_t     = r_t - 34'sd1;
                        wr_idx  = r_base + adr_s;
                        wr_data = r_rhs;
                        wr_go   = 1'b1;
                    end
                    pl0sm_pkg::CMD_CAL: begin
                        wr_idx  = r_t + 34'sd1;
                        wr_data = r_base[DW-1:0];
                        wr_go   = 1'b1;
                        n_state = pl0sm_pkg::S_WR2;
                    end
                    pl0sm_pkg::CMD_INT: begin
                        n_t = r_t + adr_s;
                    end
                    pl0sm_pkg::CMD_JMP: begin
                        n_p = r_adr;
                    end
                    pl0sm_pkg::CMD_JPC: begin
                        if (r_rhs == 32'd1) begin
                            n_p = r_adr;
                        end
                        n_t = r_t - 34'sd1;
                    end
                    default: begin
                    end
                endcase
            end
            pl0sm_pkg::S_WR2: begin
                wr_idx  = r_t + 34'sd2;
                wr_data = {20'd0, r_fb};
                wr_go   = 1'b1;
                n_state = pl0sm_pkg::S_WR3;
            end
            pl0sm_pkg::S_WR3: begin
                wr_idx  = r_t + 34'sd3;
                wr_data = {21'd0, r_p};
                wr_go   = 1'b1;
                n_fb    = r_t[pl0sm_pkg::FB_W-1:0] + 12'd1;
                n_p     = r_adr;
                n_state = pl0sm_pkg::S_TOP;
            end
            pl0sm_pkg::S_TOP: begin
                rd_idx  = top_s;
                n_oob   = !f_in_range(top_s);
                n_top   = r_t[pl0sm_pkg::TOP_W-1:0];
                n_pc    = r_p;
                n_state = pl0sm_pkg::S_TOP_W;
            end
            pl0sm_pkg::S_TOP_W: begin
                n_out_pc    = r_pc;
                n_out_top   = r_top;
                n_out_val   = rdata;
                n_out_halt  = (r_pc == '0);
                n_out_fault = r_fault;
                n_state     = pl0sm_pkg::S_OUT;
            end
            pl0sm_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = pl0sm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pl0sm_pkg::S_IDLE;
            end
        endcase

        if (rd_go) begin
            n_oob = !f_in_range(rd_idx);
            if (!f_in_range(rd_idx)) begin
                n_fault = pl0sm_pkg::FAULT_STACK;
            end
        end
        if (wr_go) begin
            if (f_in_range(wr_idx)) begin
                ram_we    = 1'b1;
                ram_waddr = wr_idx[AW-1:0];
                ram_wdata = wr_data;
            end else begin
                n_fault = pl0sm_pkg::FAULT_STACK;
            end
        end
    end

    assign ram_raddr = rd_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pl0sm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_top   <= -13'sd1;
            r_fb    <= '0;
            r_pc    <= '0;
            r_fault <= pl0sm_pkg::FAULT_NONE;
            r_oob   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
            r_fb    <= n_fb;
            r_pc    <= n_pc;
            r_fault <= n_fault;
            r_oob   <= n_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cnt       <= n_cnt;
        r_adr       <= n_adr;
        r_t         <= n_t;
        r_p         <= n_p;
        r_base      <= n_base;
        r_lhs       <= n_lhs;
        r_rhs       <= n_rhs;
        r_dcnt      <= n_dcnt;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dvs       <= n_dvs;
        r_neg       <= n_neg;
        r_out_pc    <= n_out_pc;
        r_out_top   <= n_out_top;
        r_out_val   <= n_out_val;
        r_out_halt  <= n_out_halt;
        r_out_fault <= n_out_fault;
    end

    assign o_stall     = (r_state != pl0sm_pkg::S_IDLE);
    assign o_valid     = (r_state == pl0sm_pkg::S_OUT);
    assign o_next_pc   = r_out_pc;
    assign o_top_index = r_out_top;
    assign o_top_value = $signed(r_out_val);
    assign o_halted    = r_out_halt;
    assign o_fault     = r_out_fault;

endmodule

>>> rtl/pl0sm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pl0sm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/pl0_pcode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PL/0 stack machine checker
// Watches the instruction and result channels, runs its own model of the
// stack machine on each accepted request and compares every result with it.
// ----------------------------------------------------------------------------
module pl0_pcode_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_command,
    input  logic [1:0]         i_level,
    input  logic [10:0]        i_address,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [10:0]        i_next_pc,
    input  logic signed [12:0] i_top_index,
    input  logic signed [31:0] i_top_value,
    input  logic               i_halted,
    input  logic [1:0]         i_fault,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    localparam int DEPTH = 4096;

    typedef struct packed {
        logic [10:0]        pc;
        logic signed [12:0] top;
        logic signed [31:0] val;
        logic               halt;
        logic [1:0]         flt;
    } t_outcome;

    logic signed [31:0] stack_mem [DEPTH];
    logic signed [12:0] top_ptr;
    logic [11:0]        frame;
    logic [10:0]        pc_reg;
    logic [1:0]         step_flt;
    t_outcome           outcome_q[$];

    function automatic logic signed [31:0] mem_read(input longint idx);
        if (idx < 0 || idx >= DEPTH) begin
            step_flt = pl0sm_pkg::FAULT_STACK;
            return 0;
        end
        return stack_mem[idx];
    endfunction

    function automatic void mem_write(input longint idx, input logic signed [31:0] v);
        if (idx < 0 || idx >= DEPTH) begin
            step_flt = pl0sm_pkg::FAULT_STACK;
            return;
        end
        stack_mem[idx] = v;
    endfunction

    function automatic longint base_of(input logic [1:0] lev);
        longint b;
        b = frame;
        for (int k = 0; k < lev; k++) b = mem_read(b);
        return b;
    endfunction

    function automatic logic signed [31:0] arith(input logic [10:0] op,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        case (op)
            pl0sm_pkg::OPR_ADD: return x + y;
            pl0sm_pkg::OPR_SUB: return x - y;
            pl0sm_pkg::OPR_MUL: return x * y;
            pl0sm_pkg::OPR_DIV: begin
                if (y == 0) begin
                    if (step_flt == pl0sm_pkg::FAULT_NONE) step_flt = pl0sm_pkg::FAULT_DIV;
                    return 0;
                end
                if (x == 32'sh8000_0000 && y == -1) return x;
                return x / y;
            end
            pl0sm_pkg::OPR_EQ:  return {31'd0, x == y};
            pl0sm_pkg::OPR_NE:  return {31'd0, x != y};
            pl0sm_pkg::OPR_LT:  return {31'd0, x < y};
            pl0sm_pkg::OPR_GE:  return {31'd0, x >= y};
            pl0sm_pkg::OPR_GT:  return {31'd0, x > y};
            default:            return {31'd0, x <= y};
        endcase
    endfunction

    function automatic t_outcome execute(input logic [2:0] cmd, input logic [1:0] lev,
                                         input logic [10:0] adr);
        longint t;
        logic [10:0] p;
        logic signed [31:0] y;
        logic signed [31:0] v;
        longint ix;
        t_outcome r;
        t = top_ptr;
        p = pc_reg + 11'd1;
        step_flt = pl0sm_pkg::FAULT_NONE;
        case (cmd)
            pl0sm_pkg::CMD_LIT: begin
                t = t + 1;
                mem_write(t, {21'd0, adr});
            end
            pl0sm_pkg::CMD_OPR: begin
                if (adr == pl0sm_pkg::OPR_RET) begin
                    t = longint'(frame) - 1;
                    p = 11'(mem_read(t + 3));
                    frame = 12'(mem_read(t + 2));
                end else if (adr == pl0sm_pkg::OPR_NEG) begin
                    mem_write(t, -mem_read(t));
                end else if (adr == pl0sm_pkg::OPR_ODD) begin
                    mem_write(t, mem_read(t) & 32'sd1);
                end else if ((adr >= pl0sm_pkg::OPR_ADD && adr <= pl0sm_pkg::OPR_DIV) ||
                             (adr >= pl0sm_pkg::OPR_EQ && adr <= pl0sm_pkg::OPR_LE)) begin
                    t = t - 1;
                    y = mem_read(t + 1);
                    v = mem_read(t);
                    mem_write(t, arith(adr, v, y));
                end
            end
            pl0sm_pkg::CMD_LOD: begin
                ix = base_of(lev) + adr;
                v = mem_read(ix);
                t = t + 1;
                mem_write(t, v);
            end
            pl0sm_pkg::CMD_STO: begin
                ix = base_of(lev) + adr;
                mem_write(ix, mem_read(t));
                t = t - 1;
            end
            pl0sm_pkg::CMD_CAL: begin
                v = 32'(base_of(lev));
                mem_write(t + 1, v);
                mem_write(t + 2, {20'd0, frame});
                mem_write(t + 3, {21'd0, p});
                frame = 12'(t + 1);
                p = adr;
            end
            pl0sm_pkg::CMD_INT: t = t + adr;
            pl0sm_pkg::CMD_JMP: p = adr;
            default: begin
                if (mem_read(t) == 1) p = adr;
                t = t - 1;
            end
        endcase
        top_ptr = 13'(t);
        pc_reg = p;
        r.pc = p;
        r.top = top_ptr;
        r.val = (top_ptr >= 0) ? stack_mem[top_ptr] : 0;
        r.halt = (p == 0);
        r.flt = step_flt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", o_results, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
        top_ptr = -1;
        frame = 0;
        pc_reg = 0;
        foreach (stack_mem[k]) stack_mem[k] = 0;
    end

    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $display("result with no instruction outstanding");
                o_errors++;
            end else begin
                w = outcome_q.pop_front();
                if (i_next_pc !== w.pc) report_mismatch("next_pc", i_next_pc, w.pc);
                if (i_top_index !== w.top) report_mismatch("top_index", i_top_index, w.top);
                if (i_top_value !== w.val) report_mismatch("top_value", i_top_value, w.val);
                if (i_halted !== w.halt) report_mismatch("halted", i_halted, w.halt);
                if (i_fault !== w.flt) report_mismatch("fault", i_fault, w.flt);
            end
            o_results++;
        end
        if (i_rst_n && i_valid && !i_in_stall)
            outcome_q.push_back(execute(i_command, i_level, i_address));
        o_pending = outcome_q.size();
    end

endmodule

>>> verif/pl0_pcode_stack_machine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PL/0 stack machine testbench
// Drives directed and random p-code programs with random gaps and output
// stalls; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module pl0_pcode_stack_machine_tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_command;
    logic [1:0]         i_level;
    logic [10:0]        i_address;
    logic               o_valid;
    logic               i_stall;
    logic [10:0]        o_next_pc;
    logic signed [12:0] o_top_index;
    logic signed [31:0] o_top_value;
    logic               o_halted;
    logic [1:0]         o_fault;
    int                 errors;
    int                 pending;
    int                 results;
    int                 sent;
    longint             cycles;
    bit                 hold_long;

    pl0_pcode_stack_machine u_top (.*);

    pl0_pcode_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_command, .i_level,
        .i_address, .i_out_valid(o_valid), .i_out_stall(i_stall), .i_next_pc(o_next_pc),
        .i_top_index(o_top_index), .i_top_value(o_top_value), .i_halted(o_halted),
        .i_fault(o_fault), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(60, 20);
        return $urandom_range(4, 1);
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [1:0] lev,
                                input logic [10:0] adr);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_command = cmd;
        i_level = lev;
        i_address = adr;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic binop_pair(input logic [10:0] op);
        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd6);
        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd9);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, op);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_request();
        logic [10:0] adr;
        int pick;
        pick = $urandom_range(99);
        adr = 11'($urandom_range(40));
        if (pick < 25) begin
            if ($urandom_range(3) == 0) adr = 11'($urandom);
            send_request(pl0sm_pkg::CMD_LIT, 2'($urandom), adr);
        end else if (pick < 55) begin
            send_request(pl0sm_pkg::CMD_OPR, 2'($urandom),
                         11'(($urandom_range(9) == 0) ? $urandom : $urandom_range(15)));
        end else if (pick < 65) begin
            send_request(pl0sm_pkg::CMD_LOD, 2'($urandom), adr);
        end else if (pick < 75) begin
            send_request(pl0sm_pkg::CMD_STO, 2'($urandom), adr);
        end else if (pick < 80) begin
            send_request(pl0sm_pkg::CMD_CAL, 2'($urandom), 11'($urandom));
        end else if (pick < 88) begin
            send_request(pl0sm_pkg::CMD_INT, 2'($urandom),
                         11'(($urandom_range(29) == 0) ? $urandom : $urandom_range(6)));
        end else if (pick < 93) begin
            send_request(pl0sm_pkg::CMD_JMP, 2'($urandom), 11'($urandom));
        end else begin
            send_request(pl0sm_pkg::CMD_JPC, 2'($urandom), 11'($urandom));
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_long) begin
            i_stall <= 1'b1;
        end else if ($urandom_range(99) < 15) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("pl0_pcode_stack_machine test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = '0;
        i_level = '0;
        i_address = '0;
        sent = 0;
        cycles = 0;
        hold_long = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd2047);
        send_request(pl0sm_pkg::CMD_LIT, 2'd3, 11'd0);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_DIV);
        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd5);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_NEG);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_ODD);
        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd7);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_MUL);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, 11'd7);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, 11'd2047);
        binop_pair(pl0sm_pkg::OPR_ADD);
        binop_pair(pl0sm_pkg::OPR_SUB);
        binop_pair(pl0sm_pkg::OPR_EQ);
        binop_pair(pl0sm_pkg::OPR_NE);
        binop_pair(pl0sm_pkg::OPR_LT);
        binop_pair(pl0sm_pkg::OPR_GE);
        binop_pair(pl0sm_pkg::OPR_GT);
        binop_pair(pl0sm_pkg::OPR_LE);
        send_request(pl0sm_pkg::CMD_LIT, 2'd0, 11'd9);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_LT);
        send_request(pl0sm_pkg::CMD_JPC, 2'd0, 11'd1234);
        send_request(pl0sm_pkg::CMD_INT, 2'd0, 11'd3);
        send_request(pl0sm_pkg::CMD_STO, 2'd3, 11'd1);
        send_request(pl0sm_pkg::CMD_LOD, 2'd2, 11'd2047);
        send_request(pl0sm_pkg::CMD_CAL, 2'd1, 11'd100);
        send_request(pl0sm_pkg::CMD_INT, 2'd0, 11'd2);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_RET);
        send_request(pl0sm_pkg::CMD_JMP, 2'd0, 11'd0);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_GE);
        send_request(pl0sm_pkg::CMD_INT, 2'd0, 11'd2047);
        send_request(pl0sm_pkg::CMD_LOD, 2'd0, 11'd1);
        send_request(pl0sm_pkg::CMD_INT, 2'd0, 11'd2047);
        send_request(pl0sm_pkg::CMD_OPR, 2'd0, pl0sm_pkg::OPR_RET);
        drain();

        for (int n = 0; n < 1350; n++) begin
            if (n == 400) begin
                hold_long = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge i_clk);
                        hold_long = 1'b0;
                    end
                join_none
            end
            if (n == 800) drain();
            random_request();
        end
        drain();
        repeat (100) @(negedge i_clk);
        $display("Ran %0d instructions of every opcode and operator, with stalls and gaps;",
                 sent);
        $display("%0d results were checked.", results);
        if (errors == 0) begin
            $display("pl0_pcode_stack_machine test passed");
        end else begin
            $display("pl0_pcode_stack_machine test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pl0sm_pkg.sv
rtl/pl0sm_ram.sv
rtl/pl0_pcode_stack_machine.sv
verif/pl0_pcode_checker.sv
verif/pl0_pcode_stack_machine_tb.sv
